>>> src/ttwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttwm_pkg
// Shared types, constants and the tempo ROM of the tap tempo wiper mapper.
// ----------------------------------------------------------------------------
package ttwm_pkg;

  localparam int unsigned TABLE_ENTRIES = 255;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned TEMPO_W = 11;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned FACTOR_W = 17;
  localparam int unsigned PROD_W = CNT_W + FACTOR_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_POT    = 2'd2;

  localparam logic [1:0] REG_MAX_DELAY = 2'd0;
  localparam logic [1:0] REG_FACTOR    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [TEMPO_W-1:0]  DELAY_FLOOR     = 11'd41;
  localparam logic [TEMPO_W-1:0]  MAX_DELAY_RST   = 11'd1184;
  localparam logic [FACTOR_W-1:0] FACTOR_RST      = 17'h10000;
  localparam logic [CNT_W-1:0]    TIMEOUT_RST     = 16'd1984;
  localparam logic [FACTOR_W-1:0] ONE_Q16         = 17'h10000;
  localparam logic [CNT_W-1:0]    SAT16           = 16'hFFFF;

  localparam logic [TEMPO_W-1:0] TEMPO_ROM [256] = '{
    11'd41,  11'd42,  11'd44,  11'd47,  11'd52,  11'd58,  11'd63,  11'd68,
    11'd73,  11'd77,  11'd82,  11'd86,  11'd90,  11'd95,  11'd99,  11'd104,
    11'd108, 11'd112, 11'd117, 11'd121, 11'd126, 11'd130, 11'd135, 11'd140,
    11'd145, 11'd149, 11'd154, 11'd159, 11'd164, 11'd168, 11'd173, 11'd177,
    11'd182, 11'd186, 11'd191, 11'd195, 11'd200, 11'd204, 11'd209, 11'd213,
    11'd217, 11'd221, 11'd225, 11'd230, 11'd234, 11'd238, 11'd243, 11'd247,
    11'd252, 11'd256, 11'd260, 11'd265, 11'd269, 11'd274, 11'd278, 11'd282,
    11'd287, 11'd292, 11'd296, 11'd301, 11'd305, 11'd310, 11'd315, 11'd319,
    11'd323, 11'd328, 11'd332, 11'd337, 11'd341, 11'd345, 11'd350, 11'd354,
    11'd359, 11'd363, 11'd367, 11'd372, 11'd376, 11'd380, 11'd384, 11'd388,
    11'd393, 11'd397, 11'd402, 11'd406, 11'd410, 11'd415, 11'd419, 11'd423,
    11'd427, 11'd431, 11'd436, 11'd440, 11'd444, 11'd449, 11'd453, 11'd458,
    11'd462, 11'd466, 11'd470, 11'd475, 11'd479, 11'd483, 11'd488, 11'd492,
    11'd496, 11'd501, 11'd505, 11'd510, 11'd514, 11'd518, 11'd523, 11'd527,
    11'd531, 11'd535, 11'd540, 11'd544, 11'd548, 11'd553, 11'd557, 11'd561,
    11'd566, 11'd570, 11'd574, 11'd579, 11'd583, 11'd587, 11'd591, 11'd595,
    11'd600, 11'd604, 11'd608, 11'd613, 11'd617, 11'd621, 11'd626, 11'd630,
    11'd634, 11'd638, 11'd642, 11'd646, 11'd651, 11'd655, 11'd659, 11'd663,
    11'd668, 11'd672, 11'd676, 11'd681, 11'd685, 11'd688, 11'd693, 11'd697,
    11'd701, 11'd706, 11'd710, 11'd718, 11'd723, 11'd727, 11'd731, 11'd735,
    11'd740, 11'd744, 11'd748, 11'd752, 11'd756, 11'd761, 11'd765, 11'd770,
    11'd773, 11'd778, 11'd782, 11'd786, 11'd791, 11'd795, 11'd799, 11'd803,
    11'd807, 11'd812, 11'd816, 11'd820, 11'd824, 11'd829, 11'd833, 11'd837,
    11'd841, 11'd846, 11'd850, 11'd854, 11'd858, 11'd862, 11'd866, 11'd871,
    11'd875, 11'd879, 11'd883, 11'd888, 11'd892, 11'd896, 11'd900, 11'd905,
    11'd909, 11'd913, 11'd917, 11'd921, 11'd925, 11'd929, 11'd933, 11'd938,
    11'd942, 11'd946, 11'd951, 11'd955, 11'd959, 11'd963, 11'd967, 11'd971,
    11'd976, 11'd980, 11'd984, 11'd988, 11'd992, 11'd996, 11'd1000, 11'd1005,
    11'd1009, 11'd1013, 11'd1018, 11'd1022, 11'd1027, 11'd1028, 11'd1033, 11'd1038,
    11'd1042, 11'd1046, 11'd1051, 11'd1055, 11'd1059, 11'd1063, 11'd1068, 11'd1071,
    11'd1076, 11'd1080, 11'd1084, 11'd1088, 11'd1093, 11'd1097, 11'd1101, 11'd1105,
    11'd1109, 11'd1113, 11'd1118, 11'd1122, 11'd1126, 11'd1130, 11'd1134, 11'd2047
  };

  function automatic logic [TEMPO_W-1:0] rom(input logic [IDX_W-1:0] idx);
    return TEMPO_ROM[idx];
  endfunction

  typedef struct packed {
    logic [1:0] kind;
    logic       button_pressed;
    logic       past_half_ms;
  } in_t;

  typedef struct packed {
    logic             wiper_valid;
    logic [IDX_W-1:0] wiper_position;
    logic             beat_pulse;
    logic             tap_mode;
  } out_t;

  typedef struct packed {
    logic [TEMPO_W-1:0]  max_delay_ms;
    logic [FACTOR_W-1:0] division_factor;
    logic [CNT_W-1:0]    tap_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic sum;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic tap;
    logic search_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> src/ttwm_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttwm_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module ttwm_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output ttwm_pkg::cfg_t         cfg_o
);

  ttwm_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        ttwm_pkg::REG_MAX_DELAY: cfg_d.max_delay_ms    = pwdata[ttwm_pkg::TEMPO_W-1:0];
        ttwm_pkg::REG_FACTOR:    cfg_d.division_factor = pwdata[ttwm_pkg::FACTOR_W-1:0];
        ttwm_pkg::REG_TIMEOUT:   cfg_d.tap_timeout_ms  = pwdata[ttwm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ttwm_pkg::REG_MAX_DELAY: prdata = 32'(cfg_q.max_delay_ms);
      ttwm_pkg::REG_FACTOR:    prdata = 32'(cfg_q.division_factor);
      ttwm_pkg::REG_TIMEOUT:   prdata = 32'(cfg_q.tap_timeout_ms);
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_delay_ms    <= ttwm_pkg::MAX_DELAY_RST;
      cfg_q.division_factor <= ttwm_pkg::FACTOR_RST;
      cfg_q.tap_timeout_ms  <= ttwm_pkg::TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> src/ttwm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttwm_ctrl
// Sequencer: request intake, tap multiply, tempo blend, ROM search, result.
// ----------------------------------------------------------------------------
module ttwm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ttwm_pkg::status_t status_i,
  output ttwm_pkg::cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_SUM    = 5'b00100,
    S_SEARCH = 5'b01000,
    S_PICK   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) & status_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i & in_ready_o;
        if (cmd_o.accept && status_i.tap) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_SEARCH;
      end
      S_SEARCH: begin
        if (status_i.search_done) begin
          state_d = S_PICK;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_PICK: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && status_i.tap |=> state_q == S_MUL ##2 state_q == S_SEARCH)
    else $error("tap request did not reach the search");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> in_ready_o == status_i.out_free)
    else $error("sequencer not back in idle after a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !cmd_o.accept)
    else $error("request taken while busy");

endmodule
`default_nettype wire

>>> src/ttwm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttwm_dp
// Counters, tempo arithmetic, binary search over the tempo ROM, result register.
// ----------------------------------------------------------------------------
module ttwm_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ttwm_pkg::in_t     in_data_i,
  input  wire ttwm_pkg::cfg_t    cfg_i,
  input  wire ttwm_pkg::cmd_t    cmd_i,
  output ttwm_pkg::status_t      status_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ttwm_pkg::out_t         out_data_o
);

  localparam int unsigned IW = ttwm_pkg::IDX_W;
  localparam int unsigned TW = ttwm_pkg::TEMPO_W;
  localparam int unsigned CW = ttwm_pkg::CNT_W;
  localparam int unsigned PW = ttwm_pkg::PROD_W;
  localparam int unsigned FW = ttwm_pkg::FACTOR_W;

  // tap state
  logic [CW-1:0] elapsed_q, elapsed_d;
  logic [CW-1:0] beat_q, beat_d;
  logic [CW-1:0] tap_count_q, tap_count_d;
  logic [TW-1:0] tempo_q, tempo_d;
  logic          held_q, held_d;
  logic          tap_ctrl_q, tap_ctrl_d;

  // per-tap working registers
  logic [CW-1:0] m_q;
  logic          first_q;
  logic [PW-1:0] prod_q;
  logic [IW-1:0] lo_q, hi_q;

  // result register
  logic           out_valid_q;
  ttwm_pkg::out_t out_q, out_d;
  logic           out_wr;

  // request decode
  logic          tick, btn, pot;
  logic [CW-1:0] el_inc, bt_inc, el_a, tc_a;
  logic          tmo, start, release_ev, tap;
  logic [CW:0]   m_sum;
  logic          pulse_now;

  // arithmetic and search
  logic [PW:0]   blend;
  logic [FW-1:0] t_raw, t_flr;
  logic [TW-1:0] t_clamp;
  logic [IW-1:0] mid;
  logic [TW-1:0] rom_mid, rom_lo, rom_hi;
  logic [IW-1:0] pos;
  logic          pulse_tap;

  assign tick = in_data_i.kind == ttwm_pkg::KIND_TICK;
  assign btn  = in_data_i.kind == ttwm_pkg::KIND_BUTTON;
  assign pot  = in_data_i.kind == ttwm_pkg::KIND_POT;

  always_comb begin
    el_inc     = (tick && elapsed_q != ttwm_pkg::SAT16) ? elapsed_q + 1'b1 : elapsed_q;
    bt_inc     = (tick && beat_q != ttwm_pkg::SAT16) ? beat_q + 1'b1 : beat_q;
    tmo        = el_inc > cfg_i.tap_timeout_ms;
    el_a       = tmo ? '0 : el_inc;
    tc_a       = tmo ? '0 : tap_count_q;
    start      = btn & in_data_i.button_pressed & ~held_q & (tc_a == '0);
    tap        = btn & in_data_i.button_pressed & ~held_q & (tc_a != '0);
    release_ev = btn & ~in_data_i.button_pressed & held_q;
    m_sum      = (CW+1)'(el_a) + (CW+1)'(in_data_i.past_half_ms);

    elapsed_d   = (start | tap) ? '0 : el_a;
    tap_count_d = tc_a;
    if (start) begin
      tap_count_d = CW'(1);
    end else if (tap && tc_a != ttwm_pkg::SAT16) begin
      tap_count_d = tc_a + 1'b1;
    end
    held_d = held_q;
    if (start | tap) begin
      held_d = 1'b1;
    end else if (release_ev) begin
      held_d = 1'b0;
    end
    tap_ctrl_d = tap_ctrl_q;
    if (tap) begin
      tap_ctrl_d = 1'b1;
    end else if (pot) begin
      tap_ctrl_d = 1'b0;
    end
    pulse_now = ~tap & tap_ctrl_d & (bt_inc > CW'(tempo_q));
    beat_d    = pulse_now ? '0 : bt_inc;
  end

  // tempo blend and clamp
  always_comb begin
    blend = (PW+1)'({tempo_q, 16'd0}) + (PW+1)'(prod_q) + (PW+1)'(ttwm_pkg::ONE_Q16);
    t_raw = first_q ? prod_q[PW-1:16] : blend[PW:17];
    t_flr = (t_raw < FW'(ttwm_pkg::DELAY_FLOOR)) ? FW'(ttwm_pkg::DELAY_FLOOR) : t_raw;
    t_clamp = (t_flr > FW'(cfg_i.max_delay_ms)) ? cfg_i.max_delay_ms : t_flr[TW-1:0];
    tempo_d = tempo_q;
    if (cmd_i.sum) begin
      tempo_d = t_clamp;
    end
  end

  // search probe and final pick
  always_comb begin
    mid     = IW'(((IW+1)'(lo_q) + (IW+1)'(hi_q)) >> 1);
    rom_mid = ttwm_pkg::rom(mid);
    rom_lo  = ttwm_pkg::rom(lo_q);
    rom_hi  = ttwm_pkg::rom(hi_q);
    if (tempo_q <= ttwm_pkg::rom('0)) begin
      pos = '0;
    end else if (tempo_q >= ttwm_pkg::rom(ttwm_pkg::LAST_IDX)) begin
      pos = ttwm_pkg::LAST_IDX;
    end else if ((tempo_q - rom_lo) >= (rom_hi - tempo_q)) begin
      pos = hi_q;
    end else begin
      pos = lo_q;
    end
    pulse_tap = tap_ctrl_q & (beat_q > CW'(tempo_q));
  end

  // result register
  always_comb begin
    out_wr = (cmd_i.accept & ~tap) | cmd_i.finish;
    out_d  = out_q;
    if (cmd_i.finish) begin
      out_d.wiper_valid    = 1'b1;
      out_d.wiper_position = pos;
      out_d.beat_pulse     = pulse_tap;
      out_d.tap_mode       = tap_ctrl_q;
    end else if (cmd_i.accept) begin
      out_d.wiper_valid    = 1'b0;
      out_d.wiper_position = '0;
      out_d.beat_pulse     = pulse_now;
      out_d.tap_mode       = tap_ctrl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      beat_q      <= '0;
      tap_count_q <= '0;
      tempo_q     <= '0;
      held_q      <= 1'b0;
      tap_ctrl_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tempo_q <= tempo_d;
      if (cmd_i.accept) begin
        elapsed_q   <= elapsed_d;
        beat_q      <= beat_d;
        tap_count_q <= tap_count_d;
        held_q      <= held_d;
        tap_ctrl_q  <= tap_ctrl_d;
      end else if (cmd_i.finish && pulse_tap) begin
        beat_q <= '0;
      end
      out_valid_q <= out_wr | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      m_q     <= m_sum[CW] ? ttwm_pkg::SAT16 : m_sum[CW-1:0];
      first_q <= tc_a == CW'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(m_q) * PW'(cfg_i.division_factor);
    end
    if (cmd_i.sum) begin
      lo_q <= '0;
      hi_q <= ttwm_pkg::LAST_IDX;
    end else if (cmd_i.step) begin
      if (rom_mid < tempo_q) begin
        lo_q <= mid;
      end else begin
        hi_q <= mid;
      end
    end
    if (out_wr) begin
      out_q <= out_d;
    end
  end

  assign status_o.tap         = tap;
  assign status_o.search_done = (hi_q - lo_q) <= IW'(1);
  assign status_o.out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && tap |=> tap_ctrl_q && held_q && elapsed_q == '0)
    else $error("tap did not restart the count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> hi_q > lo_q)
    else $error("search bounds crossed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sum |=> tempo_q <= $past(cfg_i.max_delay_ms))
    else $error("tempo above the upper clamp");

endmodule
`default_nettype wire

>>> src/tap_tempo_wiper_mapper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tap_tempo_wiper_mapper_top
// Tap tempo detector that maps the tapped tempo onto a wiper position.
// ----------------------------------------------------------------------------
// One request at a time. A tick, a pot override or a button sample that is
// not a tap gives its result in the cycle after acceptance. A tap runs one
// multiply of the count by the subdivision factor, one blend and clamp of the
// tempo, then a binary search of the 255-entry tempo ROM at one probe per
// cycle (up to eight probes plus the end check), and a final pick of the
// nearer neighbor. The next request is taken once the result register is
// free or being drained. No clearing pass after reset.
module tap_tempo_wiper_mapper_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ttwm_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ttwm_pkg::out_t     out_data_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);

  ttwm_pkg::cfg_t    cfg;
  ttwm_pkg::cmd_t    cmd;
  ttwm_pkg::status_t status;

  ttwm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ttwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttwm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
